FILE: sv/assert_macros.svh
// Assertion macros for the checker file.
// Guard against a second inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PMST_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define PMST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define PMST_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/pmst_pkg.sv
// Types and constants of the pending message slot table.
`timescale 1ns / 1ps

package pmst_pkg;

  // Most results that one flush may report
  localparam int MAX_RESULTS = 8;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_FIND    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_FLUSH   = 2'd3
  } pmst_kind_t;

  typedef struct packed {
    pmst_kind_t  kind;
    logic [31:0] msg_id;
    logic [7:0]  msg_flags;
    logic [47:0] hop_mac;
    logic        hop_mac_given;
    logic [47:0] final_mac;
    logic        final_mac_given;
    logic        wait_route;
    logic [3:0]  slot_number;
    logic [47:0] route_hop;
    logic        route_ok;
    logic [47:0] now_ms;
  } pmst_req_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  slot_index;
    logic [31:0] out_message_id;
    logic [47:0] send_mac;
    logic        last;
  } pmst_rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  flags;
    logic [47:0] hop;
    logic [47:0] final_mac;
    logic        waiting;
    logic [7:0]  retries;
    logic [47:0] sent_ms;
  } pmst_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } pmst_state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic fin_push;
  } pmst_cmd_t;

  typedef struct packed {
    logic skip_scan;
    logic scan_done;
    logic out_free;
  } pmst_stat_t;

endpackage

FILE: sv/pmst_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module pmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/pmst_ctrl.sv
// Controller state machine of the pending message slot table.
`timescale 1ns / 1ps

module pmst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  output pmst_pkg::pmst_cmd_t  cmd,
  input  pmst_pkg::pmst_stat_t stat
);
  import pmst_pkg::*;

  pmst_state_t state;
  pmst_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = stat.skip_scan ? ST_FIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold the closing result until the output register frees up
        if (stat.out_free) begin
          cmd.fin_push = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/pmst_datapath.sv
// Datapath of the pending message slot table: slot store, scan stage and result registers.
`timescale 1ns / 1ps

module pmst_datapath #(
  parameter int SLOTS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pmst_pkg::pmst_req_t  req,
  output pmst_pkg::pmst_rsp_t  rsp,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  pmst_pkg::pmst_cmd_t  cmd,
  output pmst_pkg::pmst_stat_t stat
);
  import pmst_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LAST_ADDR = CW'(SLOTS);
  localparam logic [6:0] SLOTS_W = 7'(SLOTS);
  localparam logic [3:0] CNT_TOP = 4'(MAX_RESULTS - 1);

  pmst_req_t   item;
  logic [CW-1:0] addr;
  logic        chk_vld;
  logic [IW-1:0] chk_idx;
  logic [3:0]  found_cnt;
  pmst_rsp_t   pend;
  logic        pend_vld;
  logic        slot_valid [SLOTS];
  logic        slot_written [SLOTS];
  logic        rsp_vld;

  pmst_entry_t cur;
  pmst_entry_t wr_entry;
  logic        ram_we;
  logic [IW-1:0] ram_raddr;

  logic        cur_valid;
  logic        cur_written;
  logic [47:0] old_hop;
  logic [47:0] old_final;
  logic [IW+2:0] idx_ext;
  logic        is_flush;
  logic        hit;
  logic        out_free;
  logic        stall;
  logic        act;
  logic        term;
  logic        addr_end;
  logic        push;
  pmst_rsp_t   hit_rsp;
  pmst_rsp_t   fin_rsp;
  pmst_rsp_t   rel_rsp;
  logic        rel_in_range;
  logic [IW+3:0] rel_ext;
  logic [IW-1:0] rel_idx;

  pmst_ram #(
    .WIDTH($bits(pmst_entry_t)),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(chk_idx),
    .wdata(wr_entry),
    .raddr(ram_raddr),
    .rdata(cur)
  );

  always_comb begin
    cur_valid   = slot_valid[chk_idx];
    cur_written = slot_written[chk_idx];
    // a slot never written holds zero MACs
    old_hop     = cur_written ? cur.hop : '0;
    old_final   = cur_written ? cur.final_mac : '0;
    idx_ext     = {3'b000, chk_idx};
    is_flush    = (item.kind == KIND_FLUSH);

    case (item.kind)
      KIND_ADD:   hit = !cur_valid;
      KIND_FIND:  hit = cur_valid && (cur.id == item.msg_id);
      KIND_FLUSH: hit = cur_valid && cur.waiting && (cur.final_mac == item.final_mac);
      default:    hit = 1'b0;
    endcase

    out_free = !rsp_vld || rsp_ready;
    // a second flush hit must first move the held one out
    stall    = cmd.scan && chk_vld && hit && is_flush && pend_vld && !out_free;
    act      = cmd.scan && chk_vld && hit && !stall;
    term     = act && (!is_flush || (found_cnt == CNT_TOP));
    addr_end = (addr == LAST_ADDR);
    push     = cmd.fin_push || (act && is_flush && pend_vld);

    if (stall) begin
      ram_raddr = chk_idx;
    end else if (addr_end) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = addr[IW-1:0];
    end

    wr_entry = cur;
    if (item.kind == KIND_ADD) begin
      wr_entry.id        = item.msg_id;
      wr_entry.flags     = item.msg_flags;
      wr_entry.hop       = item.hop_mac_given ? item.hop_mac : old_hop;
      wr_entry.final_mac = item.final_mac_given ? item.final_mac : old_final;
      wr_entry.waiting   = item.wait_route;
    end else begin
      wr_entry.hop     = item.route_hop;
      wr_entry.waiting = 1'b0;
    end
    wr_entry.retries = '0;
    wr_entry.sent_ms = item.now_ms;
    ram_we = act && ((item.kind == KIND_ADD) || is_flush);

    hit_rsp.status         = 1'b0;
    hit_rsp.slot_index     = idx_ext[2:0];
    hit_rsp.out_message_id = is_flush ? cur.id : '0;
    hit_rsp.send_mac       = is_flush ? item.route_hop : '0;
    hit_rsp.last           = 1'b0;

    if (pend_vld) begin
      fin_rsp      = pend;
      fin_rsp.last = 1'b1;
    end else begin
      fin_rsp        = '0;
      fin_rsp.status = 1'b1;
      fin_rsp.last   = 1'b1;
    end

    rel_in_range       = ({3'b000, req.slot_number} < SLOTS_W);
    rel_ext            = {{IW{1'b0}}, req.slot_number};
    rel_idx            = rel_ext[IW-1:0];
    rel_rsp            = '0;
    rel_rsp.status     = !rel_in_range;
    rel_rsp.slot_index = req.slot_number[2:0];
    rel_rsp.last       = 1'b1;

    stat.skip_scan = (req.kind == KIND_RELEASE) || ((req.kind == KIND_FLUSH) && !req.route_ok);
    stat.scan_done = cmd.scan && !stall && (term || (!chk_vld && addr_end));
    stat.out_free  = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld  <= 1'b0;
      pend_vld <= 1'b0;
      chk_vld  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i]   <= 1'b0;
        slot_written[i] <= 1'b0;
      end
    end else begin
      if (cmd.capture) begin
        chk_vld  <= 1'b0;
        pend_vld <= (req.kind == KIND_RELEASE);
        if ((req.kind == KIND_RELEASE) && rel_in_range) begin
          slot_valid[rel_idx] <= 1'b0;
        end
      end else if (cmd.scan && !stall) begin
        chk_vld <= !addr_end && !term;
      end
      if (act) begin
        pend_vld <= 1'b1;
        if (item.kind == KIND_ADD) begin
          slot_valid[chk_idx]   <= 1'b1;
          slot_written[chk_idx] <= 1'b1;
        end
      end
      if (cmd.fin_push) begin
        pend_vld <= 1'b0;
      end
      if (push) begin
        rsp_vld <= 1'b1;
      end else if (rsp_ready) begin
        rsp_vld <= 1'b0;
      end
    end
  end

  // payload and scan counters
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item      <= req;
      addr      <= '0;
      found_cnt <= '0;
      pend      <= rel_rsp;
    end else if (cmd.scan && !stall) begin
      chk_idx <= addr[IW-1:0];
      if (!addr_end) begin
        addr <= addr + CW'(1);
      end
    end
    if (act) begin
      pend      <= hit_rsp;
      found_cnt <= found_cnt + 4'd1;
    end
    if (push) begin
      rsp <= cmd.fin_push ? fin_rsp : pend;
    end
  end

  assign rsp_valid = rsp_vld;

endmodule

FILE: sv/pending_message_slot_table_top.sv
// Top level of the pending message slot table.
`timescale 1ns / 1ps
// Usage
//   The req channel (req_valid / req_ready / req) takes one command per
//   transaction: add, find by id, release slot or flush waiting route.
//   The rsp channel (rsp_valid / rsp_ready / rsp) returns the results;
//   rsp.last marks the final result of a command. Add, find and release
//   give one result; flush gives one per rewritten slot, or one empty one.
// Timing
//   Commands are handled one at a time. Release and a flush without a
//   route skip the scan. Add, find and flush walk the slot store one
//   slot a cycle through its single read port with registered data,
//   unless a flush pauses for back-pressure; add and find stop at a hit.
//   A flush holds its latest hit back one step to know which result is
//   last. req_ready rises again once the closing result is in the output
//   register, so the next command is taken while it waits to be read.
// Reset
//   rst clears every slot's valid bit and its written mark (MACs of a
//   slot never written read as zero) and empties the output register.
// Back-pressure
//   While rsp_ready is low the result register holds; a flush scan
//   pauses on a later hit and the closing step waits for space.

module pending_message_slot_table_top #(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  pmst_pkg::pmst_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output pmst_pkg::pmst_rsp_t rsp
);
  import pmst_pkg::*;

  pmst_cmd_t  cmd;
  pmst_stat_t stat;

  pmst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  pmst_datapath #(
    .SLOTS(SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

FILE: sv/pmst_checker.sv
// Port-level checker of the pending message slot table and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pmst_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input pmst_pkg::pmst_rsp_t rsp
);

  `PMST_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")
  `PMST_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "command taken while one is in work")
  `PMST_ASSERT_IMP(a_fail_is_last, rsp_valid && rsp.status, rsp.last, "failure result not marked last")
  `PMST_ASSERT_IMP(a_fail_empty, rsp_valid && rsp.status, (rsp.out_message_id == 32'd0) && (rsp.send_mac == 48'd0), "failure result carries data")

endmodule

bind pending_message_slot_table_top pmst_checker u_pmst_checker (.*);

FILE: verif/tb_pending_message_slot_table_top.sv
// Self-checking testbench for the pending message slot table top level.
`timescale 1ns / 1ps

module tb_pending_message_slot_table_top;

  import pmst_pkg::*;

  localparam int SLOTS        = 8;
  localparam int CYCLE_LIMIT  = 200000;
  // A full-table scan plus the output register, with room to spare
  localparam int DRAIN_CYCLES = 3 * (SLOTS + 3);
  localparam int RANDOM_ITEMS = 62;   // per idling phase, three phases

  localparam logic [47:0] MAC_A    = 48'hA0B1_C2D3_E4F5;
  localparam logic [47:0] MAC_NONE = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MAC_ZERO = 48'h0;

  // One row of the directed script: the command, and where the outcome can
  // be read off directly, the single closing result it must give.
  typedef struct {
    pmst_req_t cmd;
    bit        typed;
    pmst_rsp_t want;
  } script_row_t;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  pmst_req_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  pmst_rsp_t rsp;

  // Shadow copy of the slot table, updated on every accepted command
  pmst_entry_t slot_shadow [SLOTS];
  bit          slot_busy   [SLOTS];

  pmst_rsp_t   fresh_rsp [$];   // results of the command just accepted
  pmst_rsp_t   rsp_due   [$];   // results still to come from the block

  // Outcome typed into the script for the command on the bus
  bit          pin_typed;
  pmst_rsp_t   pin_want;

  int          send_gap_pct = 10;
  int          take_gap_pct = 55;
  int          errors;
  int          cycles;
  int          rsp_checked;
  int          rewrites;
  int          kind_count [4];

  logic [47:0] mac_pool [4];
  logic [31:0] id_pool  [6];

  pending_message_slot_table_top #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("watchdog expired after %0d cycles, %0d results still due",
             cycles, rsp_due.size());
    $display("tb_pending_message_slot_table_top: done, errors");
    $finish;
  end

  // Receiver: hold ready low for a share of cycles set by take_gap_pct
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  function automatic pmst_rsp_t make_rsp(logic status, logic [2:0] idx,
                                         logic [31:0] id, logic [47:0] mac,
                                         logic last);
    pmst_rsp_t r;
    r.status         = status;
    r.slot_index     = idx;
    r.out_message_id = id;
    r.send_mac       = mac;
    r.last           = last;
    return r;
  endfunction

  function automatic pmst_req_t pack_cmd(pmst_kind_t k, logic [31:0] id,
                                         logic [7:0] flags, logic [47:0] hop,
                                         logic hop_g, logic [47:0] fin,
                                         logic fin_g, logic wt,
                                         logic [3:0] slot, logic [47:0] rhop,
                                         logic rok, logic [47:0] now);
    pmst_req_t c;
    c.kind            = k;
    c.msg_id          = id;
    c.msg_flags       = flags;
    c.hop_mac         = hop;
    c.hop_mac_given   = hop_g;
    c.final_mac       = fin;
    c.final_mac_given = fin_g;
    c.wait_route      = wt;
    c.slot_number     = slot;
    c.route_hop       = rhop;
    c.route_ok        = rok;
    c.now_ms          = now;
    return c;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    $display("%0t ns  MISMATCH  %s", $time, msg);
  endtask

  // Apply one command to the shadow table and list the results it gives.
  // Add takes the lowest free slot, find the lowest live match, release
  // clears a slot in range, and a flush with a route rewrites every live
  // waiting slot bound for the target, at most MAX_RESULTS of them.
  task automatic table_apply(input pmst_req_t c);
    int pick;
    int hits;
    fresh_rsp.delete();
    pick = -1;
    hits = 0;
    case (c.kind)
      KIND_ADD: begin
        for (int k = 0; k < SLOTS; k++)
          if (!slot_busy[k] && pick < 0) pick = k;
        if (pick < 0) begin
          fresh_rsp.push_back(make_rsp(1'b1, 3'd0, '0, '0, 1'b1));
        end else begin
          slot_shadow[pick].id      = c.msg_id;
          slot_shadow[pick].flags   = c.msg_flags;
          slot_shadow[pick].waiting = c.wait_route;
          if (c.hop_mac_given)   slot_shadow[pick].hop       = c.hop_mac;
          if (c.final_mac_given) slot_shadow[pick].final_mac = c.final_mac;
          slot_shadow[pick].retries = '0;
          slot_shadow[pick].sent_ms = c.now_ms;
          slot_busy[pick]           = 1'b1;
          fresh_rsp.push_back(make_rsp(1'b0, pick[2:0], '0, '0, 1'b1));
        end
      end
      KIND_FIND: begin
        for (int k = 0; k < SLOTS; k++)
          if (slot_busy[k] && slot_shadow[k].id == c.msg_id && pick < 0)
            pick = k;
        if (pick < 0) fresh_rsp.push_back(make_rsp(1'b1, 3'd0, '0, '0, 1'b1));
        else fresh_rsp.push_back(make_rsp(1'b0, pick[2:0], '0, '0, 1'b1));
      end
      KIND_RELEASE: begin
        if (int'(c.slot_number) < SLOTS) begin
          slot_busy[c.slot_number] = 1'b0;
          fresh_rsp.push_back(make_rsp(1'b0, c.slot_number[2:0], '0, '0, 1'b1));
        end else begin
          fresh_rsp.push_back(make_rsp(1'b1, c.slot_number[2:0], '0, '0, 1'b1));
        end
      end
      KIND_FLUSH: begin
        if (c.route_ok) begin
          for (int k = 0; k < SLOTS; k++) begin
            if (hits < MAX_RESULTS && slot_busy[k] && slot_shadow[k].waiting &&
                slot_shadow[k].final_mac == c.final_mac) begin
              slot_shadow[k].hop     = c.route_hop;
              slot_shadow[k].waiting = 1'b0;
              slot_shadow[k].retries = '0;
              slot_shadow[k].sent_ms = c.now_ms;
              fresh_rsp.push_back(make_rsp(1'b0, k[2:0], slot_shadow[k].id,
                                           c.route_hop, 1'b0));
              hits++;
            end
          end
        end
        rewrites += hits;
        if (hits == 0) fresh_rsp.push_back(make_rsp(1'b1, 3'd0, '0, '0, 1'b1));
        else fresh_rsp[fresh_rsp.size() - 1].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // Compare one result with the oldest one due, field by field
  task automatic check_rsp(input pmst_rsp_t got);
    pmst_rsp_t want;
    if (rsp_due.size() == 0) begin
      note_error($sformatf("result %0d arrived with none due: %h", rsp_checked, got));
      return;
    end
    want = rsp_due.pop_front();
    if (got.status !== want.status)
      note_error($sformatf("result %0d status %b, want %b",
                           rsp_checked, got.status, want.status));
    if (got.slot_index !== want.slot_index)
      note_error($sformatf("result %0d slot_index %0d, want %0d",
                           rsp_checked, got.slot_index, want.slot_index));
    if (got.out_message_id !== want.out_message_id)
      note_error($sformatf("result %0d out_message_id %h, want %h",
                           rsp_checked, got.out_message_id, want.out_message_id));
    if (got.send_mac !== want.send_mac)
      note_error($sformatf("result %0d send_mac %h, want %h",
                           rsp_checked, got.send_mac, want.send_mac));
    if (got.last !== want.last)
      note_error($sformatf("result %0d last %b, want %b",
                           rsp_checked, got.last, want.last));
    rsp_checked++;
  endtask

  // Monitor: both handshakes are judged on the values held before the edge.
  // Check the outgoing transaction first, then predict the incoming one.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) check_rsp(rsp);
      if (req_valid && req_ready) begin
        kind_count[int'(req.kind)]++;
        table_apply(req);
        // A typed row replaces the prediction; the shadow still advances
        if (pin_typed) rsp_due.push_back(pin_want);
        else foreach (fresh_rsp[k]) rsp_due.push_back(fresh_rsp[k]);
      end
    end
  end

  // Present one command from a falling edge and hold it until it is taken.
  // Returns on the falling edge after the accepting rising edge.
  task automatic send_cmd(input pmst_req_t c, input bit typed, input pmst_rsp_t want);
    if ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    req_valid <= 1'b1;
    req       <= c;
    pin_typed  = typed;
    pin_want   = want;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Build a random command that mostly follows the table's life: adds bound
  // for a few shared MACs, finds and releases of live slots, flushes of
  // those MACs with a route. The rest is noise on every field.
  task automatic make_random(output pmst_req_t c);
    int busy;
    int r;
    int live [$];
    busy = 0;
    for (int k = 0; k < SLOTS; k++)
      if (slot_busy[k]) begin
        busy++;
        live.push_back(k);
      end
    c = pack_cmd(KIND_ADD, $urandom, 8'($urandom_range(255)), rand48(),
                 1'($urandom_range(1)), rand48(), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 4'($urandom_range(15)), rand48(),
                 1'($urandom_range(1)), rand48());
    r = $urandom_range(99);
    if (busy <= 2) r = (r < 60) ? 0 : (r < 75) ? 1 : (r < 85) ? 2 : 3;
    else if (busy >= SLOTS - 1) r = (r < 20) ? 0 : (r < 40) ? 1 : (r < 75) ? 2 : 3;
    else r = (r < 40) ? 0 : (r < 60) ? 1 : (r < 80) ? 2 : 3;
    case (r)
      0: begin
        c.kind = KIND_ADD;
        if ($urandom_range(99) < 70) c.msg_id = id_pool[$urandom_range(5)];
        if ($urandom_range(99) < 80) c.final_mac = mac_pool[$urandom_range(3)];
        c.final_mac_given = ($urandom_range(99) < 85);
        c.hop_mac_given   = ($urandom_range(99) < 70);
        c.wait_route      = ($urandom_range(99) < 60);
      end
      1: begin
        c.kind = KIND_FIND;
        if (busy > 0 && $urandom_range(99) < 60)
          c.msg_id = slot_shadow[live[$urandom_range(busy - 1)]].id;
        else if ($urandom_range(1) == 1)
          c.msg_id = id_pool[$urandom_range(5)];
      end
      2: begin
        c.kind = KIND_RELEASE;
        if (busy > 0 && $urandom_range(99) < 75)
          c.slot_number = 4'(live[$urandom_range(busy - 1)]);
      end
      default: begin
        c.kind = KIND_FLUSH;
        if ($urandom_range(99) < 80) c.final_mac = mac_pool[$urandom_range(3)];
        c.route_ok = ($urandom_range(99) < 85);
      end
    endcase
  endtask

  initial begin
    script_row_t script [$];
    pmst_req_t   c;
    pmst_rsp_t   no_rsp;
    int          send_pcts [3];
    int          take_pcts [3];

    // Drive every input to a known value from time zero
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    pin_typed = 1'b0;
    pin_want  = '0;
    errors      = 0;
    rsp_checked = 0;
    rewrites    = 0;
    foreach (kind_count[k]) kind_count[k] = 0;
    no_rsp = '0;

    // Reset leaves every slot free with zero MACs
    for (int k = 0; k < SLOTS; k++) begin
      slot_busy[k]   = 1'b0;
      slot_shadow[k] = '0;
    end
    foreach (mac_pool[k]) mac_pool[k] = rand48();
    foreach (id_pool[k])  id_pool[k]  = $urandom;

    // Directed script: empty table, bad and free releases, a full table of
    // waiting adds, overflow, finds with duplicate ids, flushes without a
    // route, with no match and of all eight slots, then reuse of a slot
    // whose MACs were not given.
    script.push_back('{pack_cmd(KIND_FIND, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO, 1'b0,
                      1'b0, 4'd0, MAC_ZERO, 1'b0, 48'h0), 1'b1,
                      make_rsp(1'b1, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_FLUSH, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO, 1'b0,
                      1'b0, 4'd0, MAC_A, 1'b1, 48'h0), 1'b1,
                      make_rsp(1'b1, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_RELEASE, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO, 1'b0,
                      1'b0, 4'd15, MAC_ZERO, 1'b0, 48'h0), 1'b1,
                      make_rsp(1'b1, 3'd7, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_RELEASE, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO, 1'b0,
                      1'b0, 4'd8, MAC_ZERO, 1'b0, 48'h0), 1'b1,
                      make_rsp(1'b1, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_RELEASE, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO, 1'b0,
                      1'b0, 4'd3, MAC_ZERO, 1'b0, 48'h0), 1'b1,
                      make_rsp(1'b0, 3'd3, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'h0000_0000, 8'h00, MAC_ZERO, 1'b1, MAC_A, 1'b1,
                      1'b1, 4'd0, MAC_ZERO, 1'b0, 48'h0), 1'b1,
                      make_rsp(1'b0, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'hFFFF_FFFF, 8'hFF, MAC_NONE, 1'b1, MAC_A, 1'b1,
                      1'b1, 4'd15, MAC_NONE, 1'b1, 48'hFFFF_FFFF_FFFF), 1'b1,
                      make_rsp(1'b0, 3'd1, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'h1234_5678, 8'h5A, 48'h0102_0304_0506, 1'b0,
                      MAC_A, 1'b1, 1'b1, 4'd2, MAC_ZERO, 1'b0, 48'h10), 1'b1,
                      make_rsp(1'b0, 3'd2, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'h8000_0001, 8'hA5, 48'h5555_AAAA_5555, 1'b1,
                      MAC_A, 1'b1, 1'b1, 4'd0, MAC_ZERO, 1'b0, 48'h20), 1'b1,
                      make_rsp(1'b0, 3'd3, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'h0000_0000, 8'h01, 48'hAAAA_5555_AAAA, 1'b1,
                      MAC_A, 1'b1, 1'b1, 4'd0, MAC_ZERO, 1'b0, 48'h30), 1'b1,
                      make_rsp(1'b0, 3'd4, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'hFFFF_FFFF, 8'h80, 48'h0000_0000_0001, 1'b1,
                      MAC_A, 1'b1, 1'b1, 4'd0, MAC_ZERO, 1'b0, 48'h40), 1'b1,
                      make_rsp(1'b0, 3'd5, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'h7FFF_FFFE, 8'h7F, 48'h8000_0000_0000, 1'b1,
                      MAC_A, 1'b1, 1'b1, 4'd0, MAC_ZERO, 1'b0, 48'h50), 1'b1,
                      make_rsp(1'b0, 3'd6, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'hDEAD_BEEF, 8'h3C, 48'h1234_5678_9ABC, 1'b1,
                      MAC_A, 1'b1, 1'b1, 4'd0, MAC_ZERO, 1'b0, 48'h60), 1'b1,
                      make_rsp(1'b0, 3'd7, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_ADD, 32'h0BAD_F00D, 8'hFF, MAC_NONE, 1'b1, MAC_NONE,
                      1'b1, 1'b1, 4'd0, MAC_ZERO, 1'b0, 48'h70), 1'b1,
                      make_rsp(1'b1, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_FIND, 32'hFFFF_FFFF, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO,
                      1'b0, 1'b0, 4'd0, MAC_ZERO, 1'b0, 48'h80), 1'b0, no_rsp});
    script.push_back('{pack_cmd(KIND_FIND, 32'h0000_0000, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO,
                      1'b0, 1'b0, 4'd0, MAC_ZERO, 1'b0, 48'h90), 1'b0, no_rsp});
    script.push_back('{pack_cmd(KIND_FLUSH, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_A, 1'b0,
                      1'b0, 4'd0, MAC_NONE, 1'b0, 48'hA0), 1'b1,
                      make_rsp(1'b1, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_FLUSH, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_NONE, 1'b0,
                      1'b0, 4'd0, MAC_NONE, 1'b1, 48'hB0), 1'b1,
                      make_rsp(1'b1, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_FLUSH, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_A, 1'b0,
                      1'b0, 4'd0, MAC_NONE, 1'b1, 48'hFFFF_FFFF_FFFF), 1'b0, no_rsp});
    script.push_back('{pack_cmd(KIND_FLUSH, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_A, 1'b0,
                      1'b0, 4'd0, 48'h0000_0000_0002, 1'b1, 48'hC0), 1'b1,
                      make_rsp(1'b1, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_RELEASE, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO, 1'b0,
                      1'b0, 4'd0, MAC_ZERO, 1'b0, 48'h0), 1'b1,
                      make_rsp(1'b0, 3'd0, '0, '0, 1'b1)});
    script.push_back('{pack_cmd(KIND_RELEASE, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO, 1'b0,
                      1'b0, 4'd7, MAC_ZERO, 1'b0, 48'h0), 1'b1,
                      make_rsp(1'b0, 3'd7, '0, '0, 1'b1)});
    // Slot 0 is reused with neither MAC given: it keeps its old ones
    script.push_back('{pack_cmd(KIND_ADD, 32'h0000_CAFE, 8'h11, 48'h0F0F_0F0F_0F0F, 1'b0,
                      48'hF0F0_F0F0_F0F0, 1'b0, 1'b1, 4'd0, MAC_ZERO, 1'b0, 48'hD0),
                      1'b0, no_rsp});
    script.push_back('{pack_cmd(KIND_FLUSH, 32'h0, 8'h00, MAC_ZERO, 1'b0, MAC_A, 1'b0,
                      1'b0, 4'd0, 48'h0000_0000_0003, 1'b1, 48'hE0), 1'b0, no_rsp});
    script.push_back('{pack_cmd(KIND_FIND, 32'h0000_0000, 8'h00, MAC_ZERO, 1'b0, MAC_ZERO,
                      1'b0, 1'b0, 4'd0, MAC_ZERO, 1'b0, 48'hF0), 1'b0, no_rsp});

    // Hold reset, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Sender idles lightly and the receiver heavily, then the reverse,
    // then both run flat out
    send_pcts = '{10, 55, 0};
    take_pcts = '{55, 10, 0};

    send_gap_pct = send_pcts[0];
    take_gap_pct = take_pcts[0];
    foreach (script[k]) send_cmd(script[k].cmd, script[k].typed, script[k].want);

    for (int p = 0; p < 3; p++) begin
      send_gap_pct = send_pcts[p];
      take_gap_pct = take_pcts[p];
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        make_random(c);
        send_cmd(c, 1'b0, no_rsp);
      end
    end
    req_valid <= 1'b0;

    // Drain: wait for every due result, then idle long enough for strays
    while (rsp_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("commands: %0d add, %0d find, %0d release, %0d flush over %0d cycles",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], cycles);
    $display("results checked: %0d, slots rewritten by flush: %0d, mismatches: %0d",
             rsp_checked, rewrites, errors);
    if (errors == 0) begin
      $display("tb_pending_message_slot_table_top: done, clean");
    end else begin
      $display("tb_pending_message_slot_table_top: done, errors");
    end
    $finish;
  end

endmodule
